/* rtl/core/assert_macros.svh */
// Assertion macros used by the checker of the allocator.
// Each macro expects signals named clk and arst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, idle during reset.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, idle during reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/core/ibal_pkg.sv */
// Shared types and constants of the indexed block allocator.
// No dependencies; used by the controller, the datapath, the top level and the checker.
package ibal_pkg;

	localparam int KEY_W       = 32;
	localparam int SIZE_W      = 10;
	localparam int OUT_BLK_W   = 16;
	localparam int STATUS_W    = 3;
	localparam int CMD_W       = 2;
	localparam int NEED_W      = 7;
	localparam int MAX_RESULTS = 16;
	localparam int CNT_W       = 5;

	// Blocks needed = size / 10, computed as (size * 205) >> 11, exact for size < 1029.
	localparam int RECIP    = 205;
	localparam int RECIP_SH = 11;
	localparam int PROD_W   = 18;

	localparam logic [CMD_W-1:0] CMD_CREATE = 2'd0;
	localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_LIST   = 2'd2;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK         = 3'd0,
		ST_NO_SPACE   = 3'd1,
		ST_NOT_FOUND  = 3'd2,
		ST_TABLE_FULL = 3'd3,
		ST_NO_FILES   = 3'd4
	} status_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic scan;
		logic rd_en;
		logic cr_step;
		logic cr_fin;
		logic del_step;
		logic list_step;
		logic list_fin;
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic scan_end;
		logic s1_last;
		logic del_hit;
		logic list_cap;
	} dp_stat_t;

endpackage

/* rtl/core/indexed_block_allocator.sv */
// A create shows its one result after the scan of all blocks and slots, a delete when
// the key is found in a live slot or at the end of the scan, and a list one result per
// live slot trailing the scan, at most MAX_RESULTS, or one no-files result when no slot is live.
// busy falls in the cycle of the final result, and no new command is taken before it.
// The scan takes one block and one slot per cycle. Results cannot be stalled.
// Reset clears the block map and slot flags at once; no clearing pass is needed.
module indexed_block_allocator
	import ibal_pkg::*;
#(
	parameter int NUM_BLOCKS = 16,
	parameter int NUM_SLOTS  = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [CMD_W-1:0]     command,
	input  logic [KEY_W-1:0]     file_key,
	input  logic [SIZE_W-1:0]    file_size,
	output logic                 result_valid,
	output logic [STATUS_W-1:0]  status,
	output logic [KEY_W-1:0]     entry_key,
	output logic [SIZE_W-1:0]    entry_size,
	output logic [OUT_BLK_W-1:0] entry_blocks,
	output logic                 last
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	ibal_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.command (command),
		.stat    (stat),
		.cmd     (cmd),
		.busy    (busy)
	);

	ibal_dp #(
		.NUM_BLOCKS (NUM_BLOCKS),
		.NUM_SLOTS  (NUM_SLOTS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.file_key     (file_key),
		.file_size    (file_size),
		.result_valid (result_valid),
		.status       (status),
		.entry_key    (entry_key),
		.entry_size   (entry_size),
		.entry_blocks (entry_blocks),
		.last         (last)
	);

endmodule

/* rtl/core/ibal_ctrl.sv */
// Controller state machine of the indexed block allocator.
// Depends on ibal_pkg for the command and status structs and the command codes.
module ibal_ctrl
	import ibal_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [CMD_W-1:0] command,
	input  dp_stat_t         stat,
	output dp_cmd_t          cmd,
	output logic             busy
);

	typedef enum logic [5:0] {
		S_IDLE      = 6'b000001,
		S_CR_SCAN   = 6'b000010,
		S_CR_FIN    = 6'b000100,
		S_DEL_SCAN  = 6'b001000,
		S_LIST_SCAN = 6'b010000,
		S_LIST_FIN  = 6'b100000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					unique case (command)
						CMD_CREATE: state_d = S_CR_SCAN;
						CMD_DELETE: state_d = S_DEL_SCAN;
						CMD_LIST:   state_d = S_LIST_SCAN;
						default:    state_d = S_IDLE;
					endcase
				end
			end
			S_CR_SCAN: begin
				if (stat.scan_end) state_d = S_CR_FIN;
			end
			S_CR_FIN: state_d = S_IDLE;
			S_DEL_SCAN: begin
				if (stat.del_hit || stat.s1_last) state_d = S_IDLE;
			end
			S_LIST_SCAN: begin
				if (stat.s1_last || stat.list_cap) state_d = S_LIST_FIN;
			end
			S_LIST_FIN: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy          = (state_q != S_IDLE);
	assign cmd.load      = start && (state_q == S_IDLE);
	assign cmd.scan      = (state_q == S_CR_SCAN) || (state_q == S_DEL_SCAN)
	                       || (state_q == S_LIST_SCAN);
	assign cmd.rd_en     = (state_q == S_DEL_SCAN) || (state_q == S_LIST_SCAN);
	assign cmd.cr_step   = (state_q == S_CR_SCAN);
	assign cmd.cr_fin    = (state_q == S_CR_FIN);
	assign cmd.del_step  = (state_q == S_DEL_SCAN);
	assign cmd.list_step = (state_q == S_LIST_SCAN);
	assign cmd.list_fin  = (state_q == S_LIST_FIN);

endmodule

/* rtl/core/ibal_dp.sv */
// Datapath of the indexed block allocator: block map, slot table memory,
// scan counter, read stage and result registers. Depends on ibal_pkg.
module ibal_dp
	import ibal_pkg::*;
#(
	parameter int NUM_BLOCKS = 16,
	parameter int NUM_SLOTS  = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  dp_cmd_t              cmd,
	output dp_stat_t             stat,
	input  logic [KEY_W-1:0]     file_key,
	input  logic [SIZE_W-1:0]    file_size,
	output logic                 result_valid,
	output logic [STATUS_W-1:0]  status,
	output logic [KEY_W-1:0]     entry_key,
	output logic [SIZE_W-1:0]    entry_size,
	output logic [OUT_BLK_W-1:0] entry_blocks,
	output logic                 last
);

	localparam int SCAN_N = (NUM_BLOCKS > NUM_SLOTS) ? NUM_BLOCKS : NUM_SLOTS;
	localparam int IDX_W  = $clog2(SCAN_N);
	localparam int SLOT_W = $clog2(NUM_SLOTS);
	localparam int BLK_W  = $clog2(NUM_BLOCKS);
	localparam int PAD_W  = (NUM_BLOCKS > OUT_BLK_W) ? NUM_BLOCKS : OUT_BLK_W;

	typedef struct packed {
		logic [KEY_W-1:0]      key;
		logic [SIZE_W-1:0]     size;
		logic [NUM_BLOCKS-1:0] blocks;
	} slot_ent_t;

	slot_ent_t mem [NUM_SLOTS];

	logic [NUM_BLOCKS-1:0] used_q;
	logic [NUM_SLOTS-1:0]  live_q;

	logic [KEY_W-1:0]      key_q;
	logic [SIZE_W-1:0]     size_q;
	logic [NEED_W-1:0]     need_q;
	logic [IDX_W-1:0]      idx_q;
	logic [NEED_W-1:0]     got_q;
	logic [NUM_BLOCKS-1:0] mask_q;
	logic                  free_found_q;
	logic [SLOT_W-1:0]     free_slot_q;

	slot_ent_t             rd_s1;
	logic                  val_s1;
	logic                  live_s1;
	logic [IDX_W-1:0]      idx_s1;

	slot_ent_t             pend_q;
	logic                  pend_v_q;
	logic [CNT_W-1:0]      n_q;

	logic [PROD_W-1:0]     need_prod;
	logic [SLOT_W-1:0]     slot_idx;
	logic [BLK_W-1:0]      blk_idx;
	logic                  slot_in;
	logic                  blk_in;
	logic                  cr_ok;
	logic                  list_hit;

	logic                  emit;
	status_t               e_status;
	logic [KEY_W-1:0]      e_key;
	logic [SIZE_W-1:0]     e_size;
	logic [NUM_BLOCKS-1:0] e_blocks;
	logic                  e_last;
	logic [PAD_W-1:0]      e_pad;

	logic                  res_valid_q;
	status_t               res_status_q;
	logic [KEY_W-1:0]      res_key_q;
	logic [SIZE_W-1:0]     res_size_q;
	logic [OUT_BLK_W-1:0]  res_blocks_q;
	logic                  res_last_q;

	assign need_prod = PROD_W'(file_size) * PROD_W'(RECIP);
	assign slot_idx  = idx_q[SLOT_W-1:0];
	assign blk_idx   = idx_q[BLK_W-1:0];
	assign slot_in   = ({1'b0, idx_q} < (IDX_W+1)'(NUM_SLOTS));
	assign blk_in    = ({1'b0, idx_q} < (IDX_W+1)'(NUM_BLOCKS));

	// The space check is taken before the table check.
	assign cr_ok     = (got_q == need_q) && free_found_q;
	assign list_hit  = val_s1 && live_s1;

	assign stat.scan_end = (idx_q == IDX_W'(SCAN_N - 1));
	assign stat.s1_last  = val_s1 && (idx_s1 == IDX_W'(SCAN_N - 1));
	assign stat.del_hit  = val_s1 && live_s1 && (rd_s1.key == key_q);
	assign stat.list_cap = list_hit && (n_q == CNT_W'(MAX_RESULTS - 1));

	always_comb begin
		emit     = 1'b0;
		e_status = ST_OK;
		e_key    = key_q;
		e_size   = size_q;
		e_blocks = '0;
		e_last   = 1'b1;
		if (cmd.cr_fin) begin
			emit = 1'b1;
			if (got_q != need_q) begin
				e_status = ST_NO_SPACE;
			end else if (!free_found_q) begin
				e_status = ST_TABLE_FULL;
			end else begin
				e_blocks = mask_q;
			end
		end else if (cmd.del_step) begin
			if (stat.del_hit) begin
				emit     = 1'b1;
				e_size   = rd_s1.size;
				e_blocks = rd_s1.blocks;
			end else if (stat.s1_last) begin
				emit     = 1'b1;
				e_status = ST_NOT_FOUND;
				e_size   = '0;
			end
		end else if (cmd.list_step) begin
			// A found entry is held back until the next one is found, so that the final one can carry last.
			if (list_hit && pend_v_q) begin
				emit     = 1'b1;
				e_key    = pend_q.key;
				e_size   = pend_q.size;
				e_blocks = pend_q.blocks;
				e_last   = 1'b0;
			end
		end else if (cmd.list_fin) begin
			emit = 1'b1;
			if (pend_v_q) begin
				e_key    = pend_q.key;
				e_size   = pend_q.size;
				e_blocks = pend_q.blocks;
			end else begin
				e_status = ST_NO_FILES;
				e_key    = '0;
				e_size   = '0;
			end
		end
	end

	assign e_pad = PAD_W'(e_blocks);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q       <= '0;
			live_q       <= '0;
			idx_q        <= '0;
			got_q        <= '0;
			free_found_q <= 1'b0;
			val_s1       <= 1'b0;
			pend_v_q     <= 1'b0;
			n_q          <= '0;
			res_valid_q  <= 1'b0;
		end else begin
			val_s1      <= cmd.rd_en;
			res_valid_q <= emit;
			if (cmd.load) begin
				idx_q        <= '0;
				got_q        <= '0;
				free_found_q <= 1'b0;
				pend_v_q     <= 1'b0;
				n_q          <= '0;
			end else if (cmd.scan && !stat.scan_end) begin
				idx_q <= idx_q + 1'b1;
			end
			if (cmd.cr_step) begin
				if (blk_in && (got_q < need_q) && !used_q[blk_idx]) begin
					got_q <= got_q + 1'b1;
				end
				if (slot_in && !free_found_q && !live_q[slot_idx]) begin
					free_found_q <= 1'b1;
				end
			end
			if (cmd.cr_fin && cr_ok) begin
				live_q[free_slot_q] <= 1'b1;
				used_q              <= used_q | mask_q;
			end
			if (cmd.del_step && stat.del_hit) begin
				live_q[idx_s1[SLOT_W-1:0]] <= 1'b0;
				used_q                     <= used_q & ~rd_s1.blocks;
			end
			if (cmd.list_step && list_hit) begin
				pend_v_q <= 1'b1;
				n_q      <= n_q + 1'b1;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			key_q  <= file_key;
			size_q <= file_size;
			need_q <= NEED_W'(need_prod >> RECIP_SH);
			mask_q <= '0;
		end else if (cmd.cr_step && blk_in && (got_q < need_q) && !used_q[blk_idx]) begin
			mask_q[blk_idx] <= 1'b1;
		end
		if (cmd.cr_step && slot_in && !free_found_q && !live_q[slot_idx]) begin
			free_slot_q <= slot_idx;
		end
		idx_s1  <= idx_q;
		live_s1 <= slot_in && live_q[slot_idx];
		if (cmd.list_step && list_hit) begin
			pend_q <= rd_s1;
		end
		res_status_q <= e_status;
		res_key_q    <= e_key;
		res_size_q   <= e_size;
		res_blocks_q <= e_pad[OUT_BLK_W-1:0];
		res_last_q   <= e_last;
	end

	// Slot table: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (cmd.cr_fin && cr_ok) begin
			mem[free_slot_q] <= '{key: key_q, size: size_q, blocks: mask_q};
		end
		if (cmd.rd_en) begin
			rd_s1 <= mem[slot_idx];
		end
	end

	assign result_valid = res_valid_q;
	assign status       = res_status_q;
	assign entry_key    = res_key_q;
	assign entry_size   = res_size_q;
	assign entry_blocks = res_blocks_q;
	assign last         = res_last_q;

endmodule

/* rtl/core/ibal_checker.sv */
// Port-level assertions for the indexed block allocator, bound to the top level.
// Depends on ibal_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ibal_checker
	import ibal_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 start,
	input logic                 busy,
	input logic [CMD_W-1:0]     command,
	input logic                 result_valid,
	input logic [STATUS_W-1:0]  status,
	input logic [OUT_BLK_W-1:0] entry_blocks,
	input logic                 last
);

	logic unused_cmd;

	assign unused_cmd = start && !busy && (command != CMD_CREATE)
	                    && (command != CMD_DELETE) && (command != CMD_LIST);

	`ASSERT_IMPLIES(a_result_after_busy, result_valid, $past(busy), "result without busy")
	`ASSERT_NEXT(a_unused_cmd_idle, unused_cmd, !busy, "unused command started work")
	`ASSERT_IMPLIES(a_more_follows, result_valid && !last, busy, "non-final result after busy")
	`ASSERT_IMPLIES(a_no_files_last, result_valid && (status == ST_NO_FILES), last, "no files not last")
	`ASSERT_IMPLIES(a_fail_no_blocks,
		result_valid && ((status == ST_NO_SPACE) || (status == ST_TABLE_FULL)),
		entry_blocks == '0, "failed create reports blocks")

endmodule

bind indexed_block_allocator ibal_checker u_ibal_checker (.*);
